FILE: hw/rtl/qghb_pkg.sv
package qghb_pkg;

   localparam int QUERY_WIDTH     = 16;
   localparam int HEIGHT_WIDTH    = 16;
   localparam int REG_WIDTH       = 48;
   localparam int REG_INDEX_WIDTH = 3;
   localparam int NUM_VERTICES    = 6;
   localparam int NUM_TRIANGLES   = 2;
   localparam int NUM_CORNERS     = 3;

   localparam logic [REG_INDEX_WIDTH-1:0] REG_VERTEX_ZERO  = 3'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_VERTEX_ONE   = 3'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_VERTEX_TWO   = 3'd2;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_VERTEX_THREE = 3'd3;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_VERTEX_FOUR  = 3'd4;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_VERTEX_FIVE  = 3'd5;

   localparam logic signed [HEIGHT_WIDTH-1:0] MISS_HEIGHT = -16'sd256;
   localparam logic signed [HEIGHT_WIDTH-1:0] HEIGHT_MAX  = 16'sh7fff;
   localparam logic signed [HEIGHT_WIDTH-1:0] HEIGHT_MIN  = 16'sh8000;
   localparam logic [31:0] SAT_POS_LIMIT = 32'd32767;
   localparam logic [31:0] SAT_NEG_LIMIT = 32'd32768;

   typedef struct packed {
      logic hit;
      logic which;
      logic neg;
   } ctl_type;

   function automatic int diff_width(input int coord_width);
      return ((coord_width > QUERY_WIDTH) ? coord_width : QUERY_WIDTH) + 1;
   endfunction

   function automatic int weight_width(input int coord_width);
      return 2 * diff_width(coord_width);
   endfunction

   function automatic int num_width(input int coord_width);
      return weight_width(coord_width) + coord_width + 2;
   endfunction

   function automatic int den_width(input int coord_width);
      return weight_width(coord_width) + 1;
   endfunction

endpackage

FILE: hw/rtl/qghb_if.sv
interface qghb_req_if;
   import qghb_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [QUERY_WIDTH-1:0] query_x;
   logic signed [QUERY_WIDTH-1:0] query_z;

   modport source (output valid, output query_x, output query_z, input ready);
   modport sink (input valid, input query_x, input query_z, output ready);
endinterface

interface qghb_rsp_if;
   import qghb_pkg::*;

   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic                           which_triangle;
   logic signed [HEIGHT_WIDTH-1:0] ground_height;

   modport source (output valid, output hit, output which_triangle, output ground_height,
                   input ready);
   modport sink (input valid, input hit, input which_triangle, input ground_height,
                 output ready);
endinterface

FILE: hw/rtl/qghb_front.sv
module qghb_front #(
   parameter int COORD_WIDTH = 16,
   localparam int UW = qghb_pkg::weight_width(COORD_WIDTH)
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic [qghb_pkg::REG_WIDTH-1:0]              vertex [qghb_pkg::NUM_VERTICES],
   input  logic                                        up_valid,
   output logic                                        up_ready,
   input  logic signed [qghb_pkg::QUERY_WIDTH-1:0]     query_x,
   input  logic signed [qghb_pkg::QUERY_WIDTH-1:0]     query_z,
   output logic                                        dn_valid,
   input  logic                                        dn_ready,
   output qghb_pkg::ctl_type                           dn_ctl,
   output logic [UW-1:0]                               dn_weight [qghb_pkg::NUM_CORNERS],
   output logic [UW-1:0]                               dn_denom,
   output logic signed [COORD_WIDTH-1:0]               dn_height [qghb_pkg::NUM_CORNERS]
);
   import qghb_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int DW = diff_width(W);
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;
   localparam int TW = PW + 3;
   localparam int NS = 4;
   localparam int CORNER [NUM_TRIANGLES][NUM_CORNERS] = '{
      '{REG_VERTEX_ZERO, REG_VERTEX_ONE, REG_VERTEX_TWO},
      '{REG_VERTEX_FOUR, REG_VERTEX_FIVE, REG_VERTEX_THREE}
   };

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS:0]   en;

   logic [3*W+REG_WIDTH-1:0] wide [NUM_VERTICES];
   logic signed [W-1:0]      vx [NUM_VERTICES];
   logic signed [W-1:0]      vy [NUM_VERTICES];
   logic signed [W-1:0]      vz [NUM_VERTICES];

   logic signed [DW-1:0] e0x_in [NUM_TRIANGLES], e0x_ff [NUM_TRIANGLES];
   logic signed [DW-1:0] e0z_in [NUM_TRIANGLES], e0z_ff [NUM_TRIANGLES];
   logic signed [DW-1:0] e1x_in [NUM_TRIANGLES], e1x_ff [NUM_TRIANGLES];
   logic signed [DW-1:0] e1z_in [NUM_TRIANGLES], e1z_ff [NUM_TRIANGLES];
   logic signed [DW-1:0] e2x_in [NUM_TRIANGLES], e2x_ff [NUM_TRIANGLES];
   logic signed [DW-1:0] e2z_in [NUM_TRIANGLES], e2z_ff [NUM_TRIANGLES];

   logic signed [PW-1:0] pd0_in [NUM_TRIANGLES], pd0_ff [NUM_TRIANGLES];
   logic signed [PW-1:0] pd1_in [NUM_TRIANGLES], pd1_ff [NUM_TRIANGLES];
   logic signed [PW-1:0] pv0_in [NUM_TRIANGLES], pv0_ff [NUM_TRIANGLES];
   logic signed [PW-1:0] pv1_in [NUM_TRIANGLES], pv1_ff [NUM_TRIANGLES];
   logic signed [PW-1:0] pw0_in [NUM_TRIANGLES], pw0_ff [NUM_TRIANGLES];
   logic signed [PW-1:0] pw1_in [NUM_TRIANGLES], pw1_ff [NUM_TRIANGLES];

   logic signed [SW-1:0] d_raw [NUM_TRIANGLES];
   logic signed [SW-1:0] v_raw [NUM_TRIANGLES];
   logic signed [SW-1:0] w_raw [NUM_TRIANGLES];
   logic signed [SW-1:0] den_in [NUM_TRIANGLES], den_ff [NUM_TRIANGLES];
   logic signed [SW-1:0] nv_in [NUM_TRIANGLES], nv_ff [NUM_TRIANGLES];
   logic signed [SW-1:0] nw_in [NUM_TRIANGLES], nw_ff [NUM_TRIANGLES];
   logic [NUM_TRIANGLES-1:0] zero_in, zero_ff;

   logic signed [TW-1:0] dt [NUM_TRIANGLES];
   logic signed [TW-1:0] vt [NUM_TRIANGLES];
   logic signed [TW-1:0] wt [NUM_TRIANGLES];
   logic signed [TW-1:0] ut [NUM_TRIANGLES];
   logic [NUM_TRIANGLES-1:0] pass;

   ctl_type             ctl_in, ctl_ff;
   logic [UW-1:0]       weight_in [NUM_CORNERS], weight_ff [NUM_CORNERS];
   logic [UW-1:0]       denom_in, denom_ff;
   logic signed [W-1:0] height_in [NUM_CORNERS], height_ff [NUM_CORNERS];

   assign en[NS] = dn_ready;
   for (genvar s = 0; s < NS; s++) begin : g_en
      assign en[s] = ~vld_ff[s] | en[s+1];
   end

   assign vld_in   = (en[NS-1:0] & {vld_ff[NS-2:0], up_valid}) | (~en[NS-1:0] & vld_ff);
   assign up_ready = en[0];
   assign dn_valid = vld_ff[NS-1];

   always_comb begin
      for (int i = 0; i < NUM_VERTICES; i++) begin
         wide[i] = {{(3*W){1'b0}}, vertex[i]};
         vz[i]   = wide[i][W-1:0];
         vy[i]   = wide[i][2*W-1:W];
         vx[i]   = wide[i][3*W-1:2*W];
      end
   end

   always_comb begin
      for (int t = 0; t < NUM_TRIANGLES; t++) begin
         e0x_in[t] = DW'(vx[CORNER[t][1]]) - DW'(vx[CORNER[t][0]]);
         e0z_in[t] = DW'(vz[CORNER[t][1]]) - DW'(vz[CORNER[t][0]]);
         e1x_in[t] = DW'(vx[CORNER[t][2]]) - DW'(vx[CORNER[t][0]]);
         e1z_in[t] = DW'(vz[CORNER[t][2]]) - DW'(vz[CORNER[t][0]]);
         e2x_in[t] = DW'(query_x) - DW'(vx[CORNER[t][0]]);
         e2z_in[t] = DW'(query_z) - DW'(vz[CORNER[t][0]]);
      end
   end

   always_comb begin
      for (int t = 0; t < NUM_TRIANGLES; t++) begin
         pd0_in[t] = e0x_ff[t] * e1z_ff[t];
         pd1_in[t] = e1x_ff[t] * e0z_ff[t];
         pv0_in[t] = e2x_ff[t] * e1z_ff[t];
         pv1_in[t] = e1x_ff[t] * e2z_ff[t];
         pw0_in[t] = e0x_ff[t] * e2z_ff[t];
         pw1_in[t] = e2x_ff[t] * e0z_ff[t];
      end
   end

   // flip all three when the winding is negative
   always_comb begin
      for (int t = 0; t < NUM_TRIANGLES; t++) begin
         d_raw[t]   = SW'(pd0_ff[t]) - SW'(pd1_ff[t]);
         v_raw[t]   = SW'(pv0_ff[t]) - SW'(pv1_ff[t]);
         w_raw[t]   = SW'(pw0_ff[t]) - SW'(pw1_ff[t]);
         den_in[t]  = d_raw[t][SW-1] ? -d_raw[t] : d_raw[t];
         nv_in[t]   = d_raw[t][SW-1] ? -v_raw[t] : v_raw[t];
         nw_in[t]   = d_raw[t][SW-1] ? -w_raw[t] : w_raw[t];
         zero_in[t] = (d_raw[t] == '0);
      end
   end

   always_comb begin
      for (int t = 0; t < NUM_TRIANGLES; t++) begin
         dt[t]   = TW'(den_ff[t]);
         vt[t]   = TW'(nv_ff[t]);
         wt[t]   = TW'(nw_ff[t]);
         ut[t]   = dt[t] - vt[t] - wt[t];
         pass[t] = !zero_ff[t]
                && !vt[t][TW-1] && (vt[t] <= dt[t])
                && !wt[t][TW-1] && (wt[t] <= dt[t])
                && !ut[t][TW-1] && (ut[t] <= dt[t]);
      end
      ctl_in.hit   = pass[0] | pass[1];
      ctl_in.which = !pass[0] && pass[1];
      ctl_in.neg   = 1'b0;
      weight_in[0] = pass[0] ? ut[0][UW-1:0] : ut[1][UW-1:0];
      weight_in[1] = pass[0] ? vt[0][UW-1:0] : vt[1][UW-1:0];
      weight_in[2] = pass[0] ? wt[0][UW-1:0] : wt[1][UW-1:0];
      denom_in     = pass[0] ? dt[0][UW-1:0] : dt[1][UW-1:0];
      for (int k = 0; k < NUM_CORNERS; k++) begin
         height_in[k] = pass[0] ? vy[CORNER[0][k]] : vy[CORNER[1][k]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         e0x_ff <= e0x_in;
         e0z_ff <= e0z_in;
         e1x_ff <= e1x_in;
         e1z_ff <= e1z_in;
         e2x_ff <= e2x_in;
         e2z_ff <= e2z_in;
      end
      if (en[1]) begin
         pd0_ff <= pd0_in;
         pd1_ff <= pd1_in;
         pv0_ff <= pv0_in;
         pv1_ff <= pv1_in;
         pw0_ff <= pw0_in;
         pw1_ff <= pw1_in;
      end
      if (en[2]) begin
         den_ff  <= den_in;
         nv_ff   <= nv_in;
         nw_ff   <= nw_in;
         zero_ff <= zero_in;
      end
      if (en[3]) begin
         ctl_ff    <= ctl_in;
         weight_ff <= weight_in;
         denom_ff  <= denom_in;
         height_ff <= height_in;
      end
   end

   assign dn_ctl    = ctl_ff;
   assign dn_weight = weight_ff;
   assign dn_denom  = denom_ff;
   assign dn_height = height_ff;

endmodule

FILE: hw/rtl/qghb_interp.sv
module qghb_interp #(
   parameter int COORD_WIDTH = 16,
   localparam int UW   = qghb_pkg::weight_width(COORD_WIDTH),
   localparam int MW   = qghb_pkg::num_width(COORD_WIDTH),
   localparam int DENW = qghb_pkg::den_width(COORD_WIDTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  qghb_pkg::ctl_type             up_ctl,
   input  logic [UW-1:0]                 up_weight [qghb_pkg::NUM_CORNERS],
   input  logic [UW-1:0]                 up_denom,
   input  logic signed [COORD_WIDTH-1:0] up_height [qghb_pkg::NUM_CORNERS],
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output qghb_pkg::ctl_type             dn_ctl,
   output logic [MW-1:0]                 dn_num,
   output logic [DENW-1:0]               dn_den
);
   import qghb_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int DW   = diff_width(W);
   localparam int PPW  = DW + 1 + W;
   localparam int SUMW = PPW + 2;
   localparam int NW   = MW - 1;
   localparam int NS   = 4;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS:0]   en;

   logic signed [PPW-1:0]  pplo_in [NUM_CORNERS], pplo_ff [NUM_CORNERS];
   logic signed [PPW-1:0]  pphi_in [NUM_CORNERS], pphi_ff [NUM_CORNERS];
   logic signed [SUMW-1:0] slo_in, slo_ff;
   logic signed [SUMW-1:0] shi_in, shi_ff;
   logic signed [NW-1:0]   n_in, n_ff;
   logic signed [MW-1:0]   n2;
   logic [MW-1:0]          num_in, num_ff;
   logic [DENW-1:0]        den_in, den_ff;
   logic [UW-1:0]          den_a_ff, den_b_ff, den_c_ff;
   ctl_type                ctl_a_ff, ctl_b_ff, ctl_c_ff, ctl_in, ctl_ff;

   assign en[NS] = dn_ready;
   for (genvar s = 0; s < NS; s++) begin : g_en
      assign en[s] = ~vld_ff[s] | en[s+1];
   end

   assign vld_in   = (en[NS-1:0] & {vld_ff[NS-2:0], up_valid}) | (~en[NS-1:0] & vld_ff);
   assign up_ready = en[0];
   assign dn_valid = vld_ff[NS-1];

   // split each weight in halves to keep the multipliers narrow
   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         pplo_in[k] = $signed({1'b0, up_weight[k][DW-1:0]}) * up_height[k];
         pphi_in[k] = $signed({1'b0, up_weight[k][UW-1:DW]}) * up_height[k];
      end
   end

   assign slo_in = SUMW'(pplo_ff[0]) + SUMW'(pplo_ff[1]) + SUMW'(pplo_ff[2]);
   assign shi_in = SUMW'(pphi_ff[0]) + SUMW'(pphi_ff[1]) + SUMW'(pphi_ff[2]);
   assign n_in   = (NW'(shi_ff) <<< DW) + NW'(slo_ff);

   // 2|N| + d, folded into one add or subtract
   always_comb begin
      n2         = MW'(n_ff) <<< 1;
      num_in     = n_ff[NW-1] ? (MW'(den_c_ff) - n2) : (MW'(den_c_ff) + n2);
      den_in     = {den_c_ff, 1'b0};
      ctl_in     = ctl_c_ff;
      ctl_in.neg = n_ff[NW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pplo_ff  <= pplo_in;
         pphi_ff  <= pphi_in;
         den_a_ff <= up_denom;
         ctl_a_ff <= up_ctl;
      end
      if (en[1]) begin
         slo_ff   <= slo_in;
         shi_ff   <= shi_in;
         den_b_ff <= den_a_ff;
         ctl_b_ff <= ctl_a_ff;
      end
      if (en[2]) begin
         n_ff     <= n_in;
         den_c_ff <= den_b_ff;
         ctl_c_ff <= ctl_b_ff;
      end
      if (en[3]) begin
         num_ff <= num_in;
         den_ff <= den_in;
         ctl_ff <= ctl_in;
      end
   end

   assign dn_ctl = ctl_ff;
   assign dn_num = num_ff;
   assign dn_den = den_ff;

endmodule

FILE: hw/rtl/qghb_div.sv
module qghb_div #(
   parameter int COORD_WIDTH = 16,
   localparam int MW   = qghb_pkg::num_width(COORD_WIDTH),
   localparam int DENW = qghb_pkg::den_width(COORD_WIDTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  qghb_pkg::ctl_type      up_ctl,
   input  logic [MW-1:0]          up_num,
   input  logic [DENW-1:0]        up_den,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output qghb_pkg::ctl_type      dn_ctl,
   output logic [COORD_WIDTH-1:0] dn_quot
);
   import qghb_pkg::*;

   localparam int QW = COORD_WIDTH;
   localparam int NS = QW;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS:0]   en;

   logic [MW-1:0]   rem_src [NS];
   logic [MW-1:0]   shifted [NS];
   logic [DENW-1:0] den_src [NS];
   logic [QW-1:0]   quo_src [NS];
   ctl_type         ctl_src [NS];
   logic [NS-1:0]   take;

   logic [MW-1:0]   rem_in [NS-1], rem_ff [NS-1];
   logic [DENW-1:0] den_ff [NS-1];
   logic [QW-1:0]   quo_in [NS], quo_ff [NS];
   ctl_type         ctl_ff [NS];

   assign en[NS]   = dn_ready;
   assign vld_in   = (en[NS-1:0] & {vld_ff[NS-2:0], up_valid}) | (~en[NS-1:0] & vld_ff);
   assign up_ready = en[0];
   assign dn_valid = vld_ff[NS-1];

   // one quotient bit per stage, most significant first
   for (genvar s = 0; s < NS; s++) begin : g_stage
      assign en[s] = ~vld_ff[s] | en[s+1];
      if (s == 0) begin : g_first
         assign rem_src[s] = up_num;
         assign den_src[s] = up_den;
         assign quo_src[s] = '0;
         assign ctl_src[s] = up_ctl;
      end else begin : g_next
         assign rem_src[s] = rem_ff[s-1];
         assign den_src[s] = den_ff[s-1];
         assign quo_src[s] = quo_ff[s-1];
         assign ctl_src[s] = ctl_ff[s-1];
      end
      assign shifted[s] = MW'(den_src[s]) << (QW - 1 - s);
      assign take[s]    = (rem_src[s] >= shifted[s]);
      assign quo_in[s]  = quo_src[s] | (QW'(take[s]) << (QW - 1 - s));
      if (s < NS - 1) begin : g_rem
         assign rem_in[s] = take[s] ? (rem_src[s] - shifted[s]) : rem_src[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NS; s++) begin
         if (en[s]) begin
            quo_ff[s] <= quo_in[s];
            ctl_ff[s] <= ctl_src[s];
         end
      end
      for (int s = 0; s < NS - 1; s++) begin
         if (en[s]) begin
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_src[s];
         end
      end
   end

   assign dn_ctl  = ctl_ff[NS-1];
   assign dn_quot = quo_ff[NS-1];

endmodule

FILE: hw/rtl/quad_ground_height_barycentric.sv
// Ground height lookup on a plane quad made of two triangles.
// Software writes the six quad corners (x, y, z packed, z in the low bits)
// through the csr port while no item is in flight; rotation is applied
// beforehand. Each req item carries a query point (x, z); each rsp item gives
// hit, which_triangle and the height interpolated from the corner y values,
// rounded to nearest, or -256 with hit low on a miss.
// Both triangles are tested side by side; the first one that holds the point
// drives a shared interpolator and a restoring divider that yields one
// quotient bit per stage.
// Throughput: one item per cycle while the receiver does not stall; from req
// accept, an item passes the front, interpolator, divider and rsp registers.
// Reset clears the corner registers to zero and empties the pipeline.
// When the receiver stalls, the rsp register holds its item and stages fill
// up behind it; req ready drops only once every stage holds an item.
module quad_ground_height_barycentric #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   qghb_req_if.sink                              req_if,
   qghb_rsp_if.source                            rsp_if,
   input  logic                                  csr_write_enable,
   input  logic [qghb_pkg::REG_INDEX_WIDTH-1:0]  csr_index,
   input  logic [qghb_pkg::REG_WIDTH-1:0]        csr_write_data
);
   import qghb_pkg::*;

   localparam int UW   = weight_width(COORD_WIDTH);
   localparam int MW   = num_width(COORD_WIDTH);
   localparam int DENW = den_width(COORD_WIDTH);

   logic [REG_WIDTH-1:0] vertex_ff [NUM_VERTICES];

   logic                          f_valid, f_ready;
   ctl_type                       f_ctl;
   logic [UW-1:0]                 f_weight [NUM_CORNERS];
   logic [UW-1:0]                 f_denom;
   logic signed [COORD_WIDTH-1:0] f_height [NUM_CORNERS];

   logic            i_valid, i_ready;
   ctl_type         i_ctl;
   logic [MW-1:0]   i_num;
   logic [DENW-1:0] i_den;

   logic                   div_valid, div_ready;
   ctl_type                div_ctl;
   logic [COORD_WIDTH-1:0] div_quot;

   logic [31:0]                    qx;
   logic signed [HEIGHT_WIDTH-1:0] height_in, height_ff;
   logic                           out_en;
   logic                           rsp_vld_ff;
   logic                           hit_ff, which_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VERTICES; i++) begin
            vertex_ff[i] <= '0;
         end
      end else if (csr_write_enable && (csr_index <= REG_VERTEX_FIVE)) begin
         vertex_ff[csr_index] <= csr_write_data;
      end
   end

   qghb_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .vertex    (vertex_ff),
      .up_valid  (req_if.valid),
      .up_ready  (req_if.ready),
      .query_x   (req_if.query_x),
      .query_z   (req_if.query_z),
      .dn_valid  (f_valid),
      .dn_ready  (f_ready),
      .dn_ctl    (f_ctl),
      .dn_weight (f_weight),
      .dn_denom  (f_denom),
      .dn_height (f_height)
   );

   qghb_interp #(.COORD_WIDTH(COORD_WIDTH)) u_interp (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (f_valid),
      .up_ready  (f_ready),
      .up_ctl    (f_ctl),
      .up_weight (f_weight),
      .up_denom  (f_denom),
      .up_height (f_height),
      .dn_valid  (i_valid),
      .dn_ready  (i_ready),
      .dn_ctl    (i_ctl),
      .dn_num    (i_num),
      .dn_den    (i_den)
   );

   qghb_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
      .clock    (clock),
      .reset    (reset),
      .up_valid (i_valid),
      .up_ready (i_ready),
      .up_ctl   (i_ctl),
      .up_num   (i_num),
      .up_den   (i_den),
      .dn_valid (div_valid),
      .dn_ready (div_ready),
      .dn_ctl   (div_ctl),
      .dn_quot  (div_quot)
   );

   assign out_en    = !rsp_vld_ff || rsp_if.ready;
   assign div_ready = out_en;

   // saturate to the signed height range
   always_comb begin
      qx = 32'(div_quot);
      if (!div_ctl.hit) begin
         height_in = MISS_HEIGHT;
      end else if (div_ctl.neg) begin
         height_in = (qx >= SAT_NEG_LIMIT) ? HEIGHT_MIN : -qx[HEIGHT_WIDTH-1:0];
      end else begin
         height_in = (qx >= SAT_POS_LIMIT) ? HEIGHT_MAX : qx[HEIGHT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_en) begin
         rsp_vld_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         hit_ff    <= div_ctl.hit;
         which_ff  <= div_ctl.which;
         height_ff <= height_in;
      end
   end

   assign rsp_if.valid          = rsp_vld_ff;
   assign rsp_if.hit            = hit_ff;
   assign rsp_if.which_triangle = which_ff;
   assign rsp_if.ground_height  = height_ff;

   a_which_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.which_triangle |-> rsp_if.hit)
      else $error("second triangle reported without a hit");

   a_miss_height: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.hit |-> rsp_if.ground_height == MISS_HEIGHT)
      else $error("miss item without the miss height");

   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      div_valid && !div_ready |=> div_valid && $stable(div_quot) && $stable(div_ctl))
      else $error("divider output changed under stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("rsp valid right after reset");

endmodule
